// ----- sv/ramr_pkg.sv -----
// ----------------------------------------------------------------------------
// ramr_pkg
// Shared widths, constants and record types for the region attribute merge
// pipeline.
// ----------------------------------------------------------------------------
package ramr_pkg;

  localparam int COORD_BITS    = 12;
  localparam int AREA_BITS     = 25;
  localparam int PCT_BITS      = 7;
  localparam int SIDE_BITS     = COORD_BITS + 1;
  localparam int BOX_BITS      = 2 * SIDE_BITS;
  localparam int FILL_NUM_BITS = AREA_BITS + PCT_BITS;
  localparam int FILL_CMP_BITS = (FILL_NUM_BITS > BOX_BITS + PCT_BITS) ?
                                 FILL_NUM_BITS : BOX_BITS + PCT_BITS;
  localparam int SIDE_NUM_BITS = SIDE_BITS + PCT_BITS;

  localparam logic [AREA_BITS-1:0] AREA_MAX     = 25'h100_0000;
  localparam logic [PCT_BITS-1:0]  PERCENT_FULL = 7'd100;

  typedef struct packed {
    logic [AREA_BITS-1:0]  area;
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] right;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] bottom;
  } rec_t;

  // Operands handed from the merge stages to the ratio divider
  typedef struct packed {
    rec_t                     rec;
    logic [BOX_BITS-1:0]      box;
    logic [FILL_NUM_BITS-1:0] fill_num;
    logic [SIDE_NUM_BITS-1:0] side_num;
    logic [SIDE_BITS-1:0]     side_den;
  } div_req_t;

endpackage

// ----- sv/ramr_ratio_div.sv -----
// ----------------------------------------------------------------------------
// ramr_ratio_div
// Pipelined restoring divider: one quotient bit per stage for the fill and
// side-equality percentages, with the merged record carried alongside.
// ----------------------------------------------------------------------------
module ramr_ratio_div
  import ramr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  div_req_t            req,
  output logic                out_valid,
  input  logic                out_stall,
  output rec_t                out_rec,
  output logic [PCT_BITS-1:0] fill_percent,
  output logic [PCT_BITS-1:0] side_percent,
  output logic                fill_clipped
);

  typedef struct packed {
    rec_t                     rec;
    logic                     clipped;
    logic [FILL_CMP_BITS-1:0] fill_rem;
    logic [BOX_BITS-1:0]      fill_den;
    logic [PCT_BITS-1:0]      fill_q;
    logic [SIDE_NUM_BITS-1:0] side_rem;
    logic [SIDE_BITS-1:0]     side_den;
    logic [PCT_BITS-1:0]      side_q;
  } div_stage_t;

  div_stage_t          first;
  div_stage_t          stage_q [PCT_BITS];
  logic [PCT_BITS-1:0] vld;
  logic [PCT_BITS:0]   rdy;

  always_comb begin
    first          = '0;
    first.rec      = req.rec;
    // area above the box saturates; the quotient of that lane is then unused
    first.clipped  = FILL_CMP_BITS'(req.rec.area) > FILL_CMP_BITS'(req.box);
    first.fill_rem = FILL_CMP_BITS'(req.fill_num);
    first.fill_den = req.box;
    first.side_rem = req.side_num;
    first.side_den = req.side_den;
  end

  assign rdy[PCT_BITS] = !out_stall;
  assign in_stall      = !rdy[0];

  for (genvar s = 0; s < PCT_BITS; s++) begin : g_step
    localparam int K = PCT_BITS - 1 - s;

    div_stage_t               src;
    div_stage_t               res;
    logic                     vin;
    logic [FILL_CMP_BITS-1:0] fill_sh;
    logic [SIDE_NUM_BITS-1:0] side_sh;

    if (s == 0) begin : g_first
      assign src = first;
      assign vin = in_valid;
    end else begin : g_rest
      assign src = stage_q[s-1];
      assign vin = vld[s-1];
    end

    assign rdy[s] = !vld[s] || rdy[s+1];

    always_comb begin
      fill_sh = FILL_CMP_BITS'(src.fill_den) << K;
      side_sh = SIDE_NUM_BITS'(src.side_den) << K;
      res     = src;
      if (src.fill_rem >= fill_sh) begin
        res.fill_rem  = src.fill_rem - fill_sh;
        res.fill_q[K] = 1'b1;
      end
      if (src.side_rem >= side_sh) begin
        res.side_rem  = src.side_rem - side_sh;
        res.side_q[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && vin) begin
        stage_q[s] <= res;
      end
    end
  end

  assign out_valid    = vld[PCT_BITS-1];
  assign out_rec      = stage_q[PCT_BITS-1].rec;
  assign fill_clipped = stage_q[PCT_BITS-1].clipped;
  assign fill_percent = stage_q[PCT_BITS-1].clipped ? PERCENT_FULL
                                                    : stage_q[PCT_BITS-1].fill_q;
  assign side_percent = stage_q[PCT_BITS-1].side_q;

endmodule

// ----- sv/region_attribute_merge_ratios.sv -----
// ----------------------------------------------------------------------------
// region_attribute_merge_ratios
// Merges two region records (area plus bounding box) and derives the fill
// percent and the side-equality percent of the merged box.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | area_a, left_a .. bottom_a, area_b, ...
//  out     | out_valid / out_stall | merged_*, fill_percent, side_percent,
//          |                       | fill_clipped
//
// One transaction enters per cycle unless the input is stalled; each result
// passes through three merge stages (sum and min/max, side lengths, box and
// scaled numerators) followed by seven divider stages, one quotient bit each.
// Reset clears only the stage valid bits. A stalled output holds; empty
// stages keep filling behind it, so input stalls only once all are full.
// ----------------------------------------------------------------------------
module region_attribute_merge_ratios
  import ramr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [AREA_BITS-1:0]  area_a,
  input  logic [COORD_BITS-1:0] left_a,
  input  logic [COORD_BITS-1:0] right_a,
  input  logic [COORD_BITS-1:0] top_a,
  input  logic [COORD_BITS-1:0] bottom_a,
  input  logic [AREA_BITS-1:0]  area_b,
  input  logic [COORD_BITS-1:0] left_b,
  input  logic [COORD_BITS-1:0] right_b,
  input  logic [COORD_BITS-1:0] top_b,
  input  logic [COORD_BITS-1:0] bottom_b,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [AREA_BITS-1:0]  merged_area,
  output logic [COORD_BITS-1:0] merged_left,
  output logic [COORD_BITS-1:0] merged_right,
  output logic [COORD_BITS-1:0] merged_top,
  output logic [COORD_BITS-1:0] merged_bottom,
  output logic [PCT_BITS-1:0]   fill_percent,
  output logic [PCT_BITS-1:0]   side_percent,
  output logic                  fill_clipped
);

  function automatic logic [SIDE_BITS-1:0] side_len(input logic [COORD_BITS-1:0] lo,
                                                     input logic [COORD_BITS-1:0] hi);
    logic [SIDE_BITS-1:0] d;
    if (hi >= lo) begin
      d = SIDE_BITS'(hi) - SIDE_BITS'(lo);
    end else begin
      d = SIDE_BITS'(lo) - SIDE_BITS'(hi);
    end
    return d + SIDE_BITS'(1);
  endfunction

  // stage 1: area sum and merged box
  logic                 s1_valid;
  rec_t                 s1_rec;
  rec_t                 s1_rec_next;
  logic [AREA_BITS:0]   area_sum;
  // stage 2: side lengths
  logic                 s2_valid;
  rec_t                 s2_rec;
  logic [SIDE_BITS-1:0] s2_w;
  logic [SIDE_BITS-1:0] s2_h;
  // stage 3: box area and scaled numerators
  logic                 s3_valid;
  div_req_t             s3_req;
  div_req_t             s3_req_next;
  logic [SIDE_BITS-1:0] side_lo;
  logic [SIDE_BITS-1:0] side_hi;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic div_stall;

  assign s3_ready = !s3_valid || !div_stall;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;

  always_comb begin
    area_sum = (AREA_BITS+1)'(area_a) + (AREA_BITS+1)'(area_b);
    s1_rec_next.area   = (area_sum > (AREA_BITS+1)'(AREA_MAX)) ? AREA_MAX
                                                               : area_sum[AREA_BITS-1:0];
    s1_rec_next.left   = (left_a < left_b) ? left_a : left_b;
    s1_rec_next.right  = (right_a > right_b) ? right_a : right_b;
    s1_rec_next.top    = (top_a < top_b) ? top_a : top_b;
    s1_rec_next.bottom = (bottom_a > bottom_b) ? bottom_a : bottom_b;
  end

  always_comb begin
    side_lo              = (s2_w < s2_h) ? s2_w : s2_h;
    side_hi              = (s2_w < s2_h) ? s2_h : s2_w;
    s3_req_next.rec      = s2_rec;
    s3_req_next.box      = BOX_BITS'(s2_w) * BOX_BITS'(s2_h);
    s3_req_next.fill_num = FILL_NUM_BITS'(s2_rec.area) * FILL_NUM_BITS'(PERCENT_FULL);
    s3_req_next.side_num = SIDE_NUM_BITS'(side_lo) * SIDE_NUM_BITS'(PERCENT_FULL);
    s3_req_next.side_den = side_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_rec <= s1_rec_next;
    end
    if (s2_ready && s1_valid) begin
      s2_rec <= s1_rec;
      s2_w   <= side_len(s1_rec.left, s1_rec.right);
      s2_h   <= side_len(s1_rec.top, s1_rec.bottom);
    end
    if (s3_ready && s2_valid) begin
      s3_req <= s3_req_next;
    end
  end

  rec_t out_rec;

  ramr_ratio_div u_div (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s3_valid),
    .in_stall     (div_stall),
    .req          (s3_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rec      (out_rec),
    .fill_percent (fill_percent),
    .side_percent (side_percent),
    .fill_clipped (fill_clipped)
  );

  assign merged_area   = out_rec.area;
  assign merged_left   = out_rec.left;
  assign merged_right  = out_rec.right;
  assign merged_top    = out_rec.top;
  assign merged_bottom = out_rec.bottom;

endmodule

// ----- test/tb_region_attribute_merge_ratios.sv -----
// ----------------------------------------------------------------------------
// tb_region_attribute_merge_ratios
// Self-checking bench for the region record merge. Each accepted pair of
// region records is run through a local predictor of the merged box, the
// saturated area sum, and the fill and side-equality percents. Results are
// compared field by field, in order, with what was predicted. A directed set
// of corner cases runs first, then randomized pairs. The sender works in
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_region_attribute_merge_ratios;
  import ramr_pkg::*;

  localparam int RANDOM_PAIRS   = 750;
  localparam int DRAIN_CYCLES   = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [AREA_BITS-1:0]  AREA_ALL  = '1;
  localparam logic [COORD_BITS-1:0] COORD_TOP = '1;

  typedef struct packed {
    rec_t a;
    rec_t b;
  } region_pair_t;

  typedef struct packed {
    rec_t                merged;
    logic [PCT_BITS-1:0] fill;
    logic [PCT_BITS-1:0] side;
    logic                clipped;
  } merge_result_t;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  class merge_scoreboard;
    merge_result_t expected_q[$];
    int            errors = 0;

    static function logic [SIDE_BITS-1:0] span(logic [COORD_BITS-1:0] lo,
                                               logic [COORD_BITS-1:0] hi);
      return ((hi >= lo) ? hi - lo : lo - hi) + 1'b1;
    endfunction

    static function merge_result_t merge_regions(region_pair_t p);
      merge_result_t        r;
      logic [AREA_BITS:0]   sum;
      logic [SIDE_BITS-1:0] w, h, shorter, longer;
      logic [BOX_BITS-1:0]  box;
      logic [63:0]          scaled;
      sum = {1'b0, p.a.area} + {1'b0, p.b.area};
      r.merged.area   = (sum > AREA_MAX) ? AREA_MAX : sum[AREA_BITS-1:0];
      r.merged.left   = (p.a.left < p.b.left) ? p.a.left : p.b.left;
      r.merged.right  = (p.a.right > p.b.right) ? p.a.right : p.b.right;
      r.merged.top    = (p.a.top < p.b.top) ? p.a.top : p.b.top;
      r.merged.bottom = (p.a.bottom > p.b.bottom) ? p.a.bottom : p.b.bottom;
      w   = span(r.merged.left, r.merged.right);
      h   = span(r.merged.top, r.merged.bottom);
      box = w * h;
      if (r.merged.area > box) begin
        r.fill    = PERCENT_FULL;
        r.clipped = 1'b1;
      end else begin
        scaled    = (64'(r.merged.area) * 64'(PERCENT_FULL)) / 64'(box);
        r.fill    = scaled[PCT_BITS-1:0];
        r.clipped = 1'b0;
      end
      shorter = (w < h) ? w : h;
      longer  = (w < h) ? h : w;
      scaled  = (64'(shorter) * 64'(PERCENT_FULL)) / 64'(longer);
      r.side  = scaled[PCT_BITS-1:0];
      return r;
    endfunction

    function void note_pair(region_pair_t p);
      expected_q.insert(expected_q.size(), merge_regions(p));
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(merge_result_t got);
      merge_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, area %0d", $time, got.merged.area);
        return;
      end
      want = expected_q.pop_front();
      compare("merged_area", want.merged.area, got.merged.area);
      compare("merged_left", want.merged.left, got.merged.left);
      compare("merged_right", want.merged.right, got.merged.right);
      compare("merged_top", want.merged.top, got.merged.top);
      compare("merged_bottom", want.merged.bottom, got.merged.bottom);
      compare("fill_percent", want.fill, got.fill);
      compare("side_percent", want.side, got.side);
      compare("fill_clipped", want.clipped, got.clipped);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [AREA_BITS-1:0]  area_a = '0;
  logic [COORD_BITS-1:0] left_a = '0;
  logic [COORD_BITS-1:0] right_a = '0;
  logic [COORD_BITS-1:0] top_a = '0;
  logic [COORD_BITS-1:0] bottom_a = '0;
  logic [AREA_BITS-1:0]  area_b = '0;
  logic [COORD_BITS-1:0] left_b = '0;
  logic [COORD_BITS-1:0] right_b = '0;
  logic [COORD_BITS-1:0] top_b = '0;
  logic [COORD_BITS-1:0] bottom_b = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [AREA_BITS-1:0]  merged_area;
  logic [COORD_BITS-1:0] merged_left;
  logic [COORD_BITS-1:0] merged_right;
  logic [COORD_BITS-1:0] merged_top;
  logic [COORD_BITS-1:0] merged_bottom;
  logic [PCT_BITS-1:0]   fill_percent;
  logic [PCT_BITS-1:0]   side_percent;
  logic                  fill_clipped;

  merge_scoreboard sb = new();
  rx_mode_t        rx_mode = RX_FREE;
  int unsigned     rx_cycle = 0;
  int unsigned     idle_cycles = 0;
  int              burst_left = 0;
  region_pair_t    corner_q[$];

  region_attribute_merge_ratios dut (.*);

  always #4 clk = ~clk;

  // Receiver stall pattern in one of four randomly chosen modes
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:     out_stall <= 1'b0;
      RX_RANDOM:   out_stall <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_stall <= (rx_cycle % 5) < 2;
      default:     out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_pair('{a: '{area_a, left_a, right_a, top_a, bottom_a},
                     b: '{area_b, left_b, right_b, top_b, bottom_b}});
    if (!rst && out_valid && !out_stall)
      sb.check_result('{merged: '{merged_area, merged_left, merged_right,
                                  merged_top, merged_bottom},
                        fill: fill_percent, side: side_percent,
                        clipped: fill_clipped});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic region_pair_t mk(int unsigned aa, int unsigned la, int unsigned ra,
                                      int unsigned ta, int unsigned ba, int unsigned ab,
                                      int unsigned lb, int unsigned rb, int unsigned tb,
                                      int unsigned bb);
    region_pair_t p;
    p.a = '{aa[AREA_BITS-1:0], la[COORD_BITS-1:0], ra[COORD_BITS-1:0],
            ta[COORD_BITS-1:0], ba[COORD_BITS-1:0]};
    p.b = '{ab[AREA_BITS-1:0], lb[COORD_BITS-1:0], rb[COORD_BITS-1:0],
            tb[COORD_BITS-1:0], bb[COORD_BITS-1:0]};
    return p;
  endfunction

  // Append one directed pair to the corner list
  function automatic void add_corner(region_pair_t p);
    corner_q.insert(corner_q.size(), p);
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord(int unsigned style,
                                                       logic [COORD_BITS-1:0] base);
    case (style)
      0: return COORD_BITS'($urandom);
      1: return base + COORD_BITS'($urandom_range(0, 15));
      default: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return COORD_TOP;
          default: return COORD_BITS'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic logic [AREA_BITS-1:0] pick_extreme_area();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return AREA_BITS'(1);
      2: return AREA_MAX;
      default: return AREA_ALL;
    endcase
  endfunction

  function automatic region_pair_t rand_pair();
    region_pair_t          p;
    int unsigned           style;
    logic [COORD_BITS-1:0] bx, by;
    logic [BOX_BITS-1:0]   box;
    longint unsigned       total;
    style = $urandom_range(0, 3);
    bx = COORD_BITS'($urandom);
    by = COORD_BITS'($urandom);
    if (style == 3) begin
      // well-formed boxes of any size
      p.a.left   = COORD_BITS'($urandom);
      p.a.right  = p.a.left + COORD_BITS'($urandom_range(0, COORD_TOP - p.a.left));
      p.a.top    = COORD_BITS'($urandom);
      p.a.bottom = p.a.top + COORD_BITS'($urandom_range(0, COORD_TOP - p.a.top));
      p.b.left   = COORD_BITS'($urandom);
      p.b.right  = p.b.left + COORD_BITS'($urandom_range(0, COORD_TOP - p.b.left));
      p.b.top    = COORD_BITS'($urandom);
      p.b.bottom = p.b.top + COORD_BITS'($urandom_range(0, COORD_TOP - p.b.top));
    end else begin
      p.a.left   = pick_coord(style, bx);
      p.a.right  = pick_coord(style, bx);
      p.a.top    = pick_coord(style, by);
      p.a.bottom = pick_coord(style, by);
      p.b.left   = pick_coord(style, bx);
      p.b.right  = pick_coord(style, bx);
      p.b.top    = pick_coord(style, by);
      p.b.bottom = pick_coord(style, by);
    end
    case ($urandom_range(0, 4))
      0: begin
        p.a.area = AREA_BITS'($urandom);
        p.b.area = AREA_BITS'($urandom);
      end
      1: begin
        p.a.area = AREA_BITS'($urandom >> $urandom_range(7, 31));
        p.b.area = AREA_BITS'($urandom >> $urandom_range(7, 31));
      end
      2: begin
        p.a.area = pick_extreme_area();
        p.b.area = pick_extreme_area();
      end
      default: begin
        // total area close to the merged box, exactly equal now and then
        box = merge_scoreboard::span(p.a.left < p.b.left ? p.a.left : p.b.left,
                                     p.a.right > p.b.right ? p.a.right : p.b.right) *
              merge_scoreboard::span(p.a.top < p.b.top ? p.a.top : p.b.top,
                                     p.a.bottom > p.b.bottom ? p.a.bottom : p.b.bottom);
        total = ($urandom_range(0, 3) == 0) ? box :
                (longint'(box) * $urandom_range(80, 110)) / 100;
        p.a.area = AREA_BITS'($urandom_range(0, total));
        p.b.area = AREA_BITS'(total - p.a.area);
      end
    endcase
    return p;
  endfunction

  // Drive one transaction; open a random gap at the end of each burst
  task automatic send_pair(region_pair_t p);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    area_a   <= p.a.area;
    left_a   <= p.a.left;
    right_a  <= p.a.right;
    top_a    <= p.a.top;
    bottom_a <= p.a.bottom;
    area_b   <= p.b.area;
    left_b   <= p.b.left;
    right_b  <= p.b.right;
    top_b    <= p.b.top;
    bottom_b <= p.b.bottom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    add_corner(mk(1, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    add_corner(mk(0, 5, 9, 5, 9, 0, 5, 9, 5, 9));
    add_corner(mk(AREA_MAX, 0, COORD_TOP, 0, COORD_TOP,
                  AREA_MAX, 0, COORD_TOP, 0, COORD_TOP));
    add_corner(mk(AREA_ALL, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP,
                  AREA_ALL, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP));
    add_corner(mk(60, 10, 19, 20, 29, 40, 12, 15, 22, 25));
    add_corner(mk(59, 10, 19, 20, 29, 40, 12, 15, 22, 25));
    add_corner(mk(1, COORD_TOP, 0, 0, 99, 1, COORD_TOP, 0, 0, 99));
    add_corner(mk(1, 0, 99, COORD_TOP, 0, 1, 0, 99, COORD_TOP, 0));
    add_corner(mk(1, 0, COORD_TOP, 7, 7, 1, 100, 200, 7, 7));
    add_corner(mk(1, 7, 7, 0, COORD_TOP, 1, 7, 7, 100, 200));
    add_corner(mk(1000, 0, 0, 0, 0, 1000, COORD_TOP, COORD_TOP,
                  COORD_TOP, COORD_TOP));
    add_corner(mk(1, 0, 2, 0, 0, 0, 0, 0, 0, 1));
    add_corner(mk(AREA_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_corner(mk(0, COORD_TOP, 0, COORD_TOP, 0, 0, COORD_TOP, 0, COORD_TOP, 0));
    add_corner(mk(12345, 100, 199, 300, 349, 777, 150, 180, 320, 340));
    add_corner(mk(AREA_MAX / 2, 0, COORD_TOP, 0, COORD_TOP,
                  AREA_MAX / 2, 0, COORD_TOP, 0, COORD_TOP));
    add_corner(mk(AREA_MAX / 2 + 1, 0, COORD_TOP, 0, COORD_TOP,
                  AREA_MAX / 2, 0, COORD_TOP, 0, COORD_TOP));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (corner_q[i]) send_pair(corner_q[i]);
    for (int n = 0; n < RANDOM_PAIRS; n++) send_pair(rand_pair());
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ramr_pkg.sv
sv/ramr_ratio_div.sv
sv/region_attribute_merge_ratios.sv
test/tb_region_attribute_merge_ratios.sv
